/* hw/rtl/windowed_mean_with_gaps_defines.svh */
// assertion macros used by the checker file wmg_checker.sv
`ifndef WINDOWED_MEAN_WITH_GAPS_DEFINES_SVH
`define WINDOWED_MEAN_WITH_GAPS_DEFINES_SVH

// same-cycle implication, disabled in reset
`define WMG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("windowed_mean_with_gaps: assertion failed");

// next-cycle implication, disabled in reset
`define WMG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("windowed_mean_with_gaps: assertion failed");

`endif

/* hw/rtl/wmg_pkg.sv */
// ----------------------------------------------------------------------------
// wmg_pkg
// Shared constants and types of the windowed mean with gaps block.
// ----------------------------------------------------------------------------
`default_nettype none

package wmg_pkg;

    localparam int WINDOW_MAX_DEF    = 64;
    localparam int SAMPLE_BITS_DEF   = 16;
    localparam int FRACTION_BITS_DEF = 8;

    // configuration register layout
    localparam int PADDR_BITS = 3;
    localparam int PDATA_BITS = 32;
    localparam int REG_BITS   = 7;

    localparam logic REG_WINDOW_SIZE = 1'b0;
    localparam logic REG_MIN_VALID   = 1'b1;

    localparam logic [REG_BITS-1:0] WINDOW_SIZE_RESET = 7'd5;
    localparam logic [REG_BITS-1:0] MIN_VALID_RESET   = 7'd0;

    // control of the sample ring
    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic wr_present;
        logic clear;
    } ring_ctl_t;

endpackage

`default_nettype wire

/* hw/rtl/windowed_mean_with_gaps.sv */
// ----------------------------------------------------------------------------
// windowed_mean_with_gaps
// Moving average over a ring of recent samples, some possibly missing.
//
//   channel   direction  handshake                   payload
//   sample    in         sample_valid/sample_stall   sample, sample_present
//   result    out        result_valid/result_stall   mean_q8, mean_valid, valid_total
//   config    in         APB (pready tied high)      window_size @0x0, min_valid @0x4
//
// a result is registered after its request is accepted: ring read at acceptance,
// the update/write-back, one quotient bit per cycle in the radix-2 divider, then
// the mean enters the output register once that is free or being taken; the next
// request is taken once the block is back in idle
// reset and a window_size write mark every ring entry missing at once
// sample_stall stays high from acceptance until the result is in the output
// register; a waiting result holds there while the next request is worked
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_mean_with_gaps #(
    parameter int WINDOW_MAX    = wmg_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS   = wmg_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = wmg_pkg::FRACTION_BITS_DEF
) (
    input  wire                                       clk,
    input  wire                                       rst_n,

    input  wire                                       sample_valid,
    output logic                                      sample_stall,
    input  wire  signed [SAMPLE_BITS-1:0]             sample,
    input  wire                                       sample_present,

    output logic                                      result_valid,
    input  wire                                       result_stall,
    output logic signed [SAMPLE_BITS+FRACTION_BITS-1:0] mean_q8,
    output logic                                      mean_valid,
    output logic [$clog2(WINDOW_MAX+1)-1:0]           valid_total,

    input  wire                                       psel,
    input  wire                                       penable,
    input  wire                                       pwrite,
    input  wire  [wmg_pkg::PADDR_BITS-1:0]            paddr,
    input  wire  [wmg_pkg::PDATA_BITS-1:0]            pwdata,
    output logic [wmg_pkg::PDATA_BITS-1:0]            prdata,
    output logic                                      pready
);
    import wmg_pkg::*;

    localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
    localparam int ADDR_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
    localparam int MEAN_BITS = SAMPLE_BITS + FRACTION_BITS;
    localparam int CMP_BITS  = ((CNT_BITS > REG_BITS) ? CNT_BITS : REG_BITS) + 1;

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_UPDATE = 4'b0010,
        ST_DIVIDE = 4'b0100,
        ST_HOLD   = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    logic [REG_BITS-1:0]         window_size_reg;
    logic [REG_BITS-1:0]         min_valid_reg;
    logic [ADDR_BITS-1:0]        write_slot_reg, write_slot_next;
    logic signed [SUM_BITS-1:0]  sum_reg, sum_next;
    logic [CNT_BITS-1:0]         count_reg, count_next;

    logic [ADDR_BITS-1:0]        slot_reg;
    logic signed [SAMPLE_BITS-1:0] sample_hold_reg;
    logic                        present_hold_reg;

    logic                        result_valid_reg;
    logic signed [MEAN_BITS-1:0] mean_reg;
    logic                        mean_valid_reg;
    logic [CNT_BITS-1:0]         total_reg;

    logic                        cfg_write;
    logic                        size_write;
    logic                        accept;
    logic                        load;
    logic [CNT_BITS-1:0]         win_size;
    logic [ADDR_BITS-1:0]        cur_slot;
    logic [CNT_BITS-1:0]         slot_inc;
    logic [CMP_BITS-1:0]         threshold;
    logic                        reach;

    ring_ctl_t                   ring_ctl;
    logic signed [SAMPLE_BITS-1:0] old_sample;
    logic                        old_present;
    logic                        div_done;
    logic signed [MEAN_BITS-1:0] div_quotient;

    assign cfg_write  = psel && penable && pwrite;
    assign size_write = cfg_write && (paddr[2] == REG_WINDOW_SIZE);
    assign accept     = sample_valid && !sample_stall;

    // effective window: zero acts as one, large values saturate
    always_comb
    begin
        if (window_size_reg == '0)
        begin
            win_size = CNT_BITS'(1);
        end
        else if (32'(window_size_reg) > WINDOW_MAX)
        begin
            win_size = CNT_BITS'(WINDOW_MAX);
        end
        else
        begin
            win_size = CNT_BITS'(window_size_reg);
        end
    end

    always_comb
    begin
        cur_slot = (CNT_BITS'(write_slot_reg) >= win_size) ? '0 : write_slot_reg;
        slot_inc = CNT_BITS'(slot_reg) + 1'b1;
        write_slot_next = (slot_inc >= win_size) ? '0 : ADDR_BITS'(slot_inc);

        sum_next = sum_reg
                 - (old_present ? SUM_BITS'(old_sample) : SUM_BITS'(0))
                 + (present_hold_reg ? SUM_BITS'(sample_hold_reg) : SUM_BITS'(0));
        count_next = count_reg - CNT_BITS'(old_present) + CNT_BITS'(present_hold_reg);

        threshold = (min_valid_reg != '0) ? CMP_BITS'(min_valid_reg)
                                          : CMP_BITS'((CMP_BITS'(win_size) + 1'b1) >> 1);
        reach = (count_reg != '0) && (CMP_BITS'(count_reg) >= threshold);
    end

    always_comb
    begin
        ring_ctl.rd_en      = accept;
        ring_ctl.wr_en      = (state_reg == ST_UPDATE);
        ring_ctl.wr_present = present_hold_reg;
        ring_ctl.clear      = size_write;
    end

    wmg_ring #(
        .DEPTH     (WINDOW_MAX),
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (SAMPLE_BITS)
    ) u_ring (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ring_ctl),
        .rd_addr    (cur_slot),
        .wr_addr    (slot_reg),
        .wr_data    (sample_hold_reg),
        .rd_data    (old_sample),
        .rd_present (old_present)
    );

    wmg_div #(
        .SUM_BITS      (SUM_BITS),
        .CNT_BITS      (CNT_BITS),
        .FRACTION_BITS (FRACTION_BITS),
        .MEAN_BITS     (MEAN_BITS)
    ) u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (state_reg == ST_UPDATE),
        .dividend (sum_next),
        .divisor  (count_next),
        .done     (div_done),
        .quotient (div_quotient)
    );

    // result enters the output register once it is free or being taken
    assign load = ((state_reg == ST_DIVIDE && div_done) || state_reg == ST_HOLD)
               && (!result_valid_reg || !result_stall);

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                state_next = ST_DIVIDE;
            end
            ST_DIVIDE:
            begin
                if (div_done)
                begin
                    state_next = load ? ST_IDLE : ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            window_size_reg  <= WINDOW_SIZE_RESET;
            min_valid_reg    <= MIN_VALID_RESET;
            write_slot_reg   <= '0;
            sum_reg          <= '0;
            count_reg        <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write)
            begin
                if (paddr[2] == REG_WINDOW_SIZE)
                begin
                    window_size_reg <= pwdata[REG_BITS-1:0];
                end
                else
                begin
                    min_valid_reg <= pwdata[REG_BITS-1:0];
                end
            end
            if (size_write)
            begin
                write_slot_reg <= '0;
                sum_reg        <= '0;
                count_reg      <= '0;
            end
            else if (state_reg == ST_UPDATE)
            begin
                write_slot_reg <= write_slot_next;
                sum_reg        <= sum_next;
                count_reg      <= count_next;
            end
            if (load)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            slot_reg         <= cur_slot;
            sample_hold_reg  <= sample;
            present_hold_reg <= sample_present;
        end
        if (load)
        begin
            mean_reg       <= reach ? div_quotient : '0;
            mean_valid_reg <= reach;
            total_reg      <= count_reg;
        end
    end

    always_comb
    begin
        case (paddr[2])
            REG_WINDOW_SIZE: prdata = PDATA_BITS'(window_size_reg);
            REG_MIN_VALID:   prdata = PDATA_BITS'(min_valid_reg);
            default:         prdata = '0;
        endcase
    end

    assign pready       = 1'b1;
    assign sample_stall = (state_reg != ST_IDLE);
    assign result_valid = result_valid_reg;
    assign mean_q8      = mean_reg;
    assign mean_valid   = mean_valid_reg;
    assign valid_total  = total_reg;

endmodule

`default_nettype wire

/* hw/rtl/wmg_ring.sv */
// ----------------------------------------------------------------------------
// wmg_ring
// Sample ring: synchronous memory with registered read plus per-entry present bits.
// ----------------------------------------------------------------------------
`default_nettype none

module wmg_ring #(
    parameter int DEPTH     = 64,
    parameter int ADDR_BITS = 6,
    parameter int DATA_BITS = 16
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wmg_pkg::ring_ctl_t          ctl,
    input  wire  [ADDR_BITS-1:0]        rd_addr,
    input  wire  [ADDR_BITS-1:0]        wr_addr,
    input  wire  signed [DATA_BITS-1:0] wr_data,
    output logic signed [DATA_BITS-1:0] rd_data,
    output logic                        rd_present
);
    import wmg_pkg::*;

    logic signed [DATA_BITS-1:0] mem [DEPTH];
    logic signed [DATA_BITS-1:0] rd_data_reg;
    logic [DEPTH-1:0]            present_bits_reg;
    logic                        rd_present_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (ctl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    // present bits make never-written entries read as missing
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_bits_reg <= '0;
            rd_present_reg   <= 1'b0;
        end
        else
        begin
            if (ctl.clear)
            begin
                present_bits_reg <= '0;
            end
            else if (ctl.wr_en)
            begin
                present_bits_reg[wr_addr] <= ctl.wr_present;
            end
            if (ctl.rd_en)
            begin
                rd_present_reg <= present_bits_reg[rd_addr];
            end
        end
    end

    assign rd_data    = rd_data_reg;
    assign rd_present = rd_present_reg;

endmodule

`default_nettype wire

/* hw/rtl/wmg_div.sv */
// ----------------------------------------------------------------------------
// wmg_div
// Radix-2 restoring divider: signed sum scaled by 2^FRACTION_BITS over count,
// truncated toward zero, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wmg_div #(
    parameter int SUM_BITS      = 23,
    parameter int CNT_BITS      = 7,
    parameter int FRACTION_BITS = 8,
    parameter int MEAN_BITS     = 24
) (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire                         start,
    input  wire  signed [SUM_BITS-1:0]  dividend,
    input  wire  [CNT_BITS-1:0]         divisor,
    output logic                        done,
    output logic signed [MEAN_BITS-1:0] quotient
);
    import wmg_pkg::*;

    localparam int NUM_BITS  = SUM_BITS + FRACTION_BITS;
    localparam int STEP_BITS = (NUM_BITS > 1) ? $clog2(NUM_BITS) : 1;

    logic                 busy_reg;
    logic                 done_reg;
    logic [STEP_BITS-1:0] step_reg;
    logic [CNT_BITS-1:0]  div_reg;
    logic [CNT_BITS-1:0]  rem_reg;
    logic [NUM_BITS-1:0]  quo_reg;
    logic                 neg_reg;

    logic [SUM_BITS-1:0]  mag;
    logic [CNT_BITS:0]    trial;
    logic [CNT_BITS:0]    diff;
    logic                 fits;
    logic [NUM_BITS-1:0]  quo_neg;

    always_comb
    begin
        mag   = dividend[SUM_BITS-1] ? SUM_BITS'(-dividend) : SUM_BITS'(dividend);
        trial = {rem_reg, quo_reg[NUM_BITS-1]};
        diff  = trial - {1'b0, div_reg};
        fits  = (trial >= {1'b0, div_reg});
        quo_neg = -quo_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= busy_reg && (step_reg == '0);
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= STEP_BITS'(NUM_BITS - 1);
            end
            else if (busy_reg)
            begin
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                end
                else
                begin
                    step_reg <= step_reg - 1'b1;
                end
            end
        end
    end

    // numerator shifts out of quo_reg while quotient bits shift in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            div_reg <= divisor;
            rem_reg <= '0;
            neg_reg <= dividend[SUM_BITS-1];
            quo_reg <= NUM_BITS'(mag) << FRACTION_BITS;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? diff[CNT_BITS-1:0] : trial[CNT_BITS-1:0];
            quo_reg <= {quo_reg[NUM_BITS-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? MEAN_BITS'(quo_neg) : MEAN_BITS'(quo_reg);

endmodule

`default_nettype wire

/* hw/rtl/wmg_checker.sv */
// ----------------------------------------------------------------------------
// wmg_checker
// Port-level assertions for windowed_mean_with_gaps, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "windowed_mean_with_gaps_defines.svh"

module wmg_checker #(
    parameter int WINDOW_MAX    = wmg_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS   = wmg_pkg::SAMPLE_BITS_DEF,
    parameter int FRACTION_BITS = wmg_pkg::FRACTION_BITS_DEF
) (
    input wire                                      clk,
    input wire                                      rst_n,
    input wire                                      sample_valid,
    input wire                                      sample_stall,
    input wire                                      result_valid,
    input wire                                      result_stall,
    input wire [SAMPLE_BITS+FRACTION_BITS-1:0]      mean_q8,
    input wire                                      mean_valid,
    input wire [$clog2(WINDOW_MAX+1)-1:0]           valid_total
);
    import wmg_pkg::*;

    // a stalled result keeps its payload
    `WMG_ASSERT_NEXT(a_result_hold, clk, rst_n, result_valid && result_stall, result_valid && $stable(mean_q8) && $stable(mean_valid) && $stable(valid_total))

    // an accepted request keeps the block busy in the next cycle
    `WMG_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, sample_valid && !sample_stall, sample_stall)

    // a valid mean needs at least one present sample
    `WMG_ASSERT_NOW(a_valid_has_count, clk, rst_n, result_valid && mean_valid, valid_total != '0)

    // an invalid mean reads as zero
    `WMG_ASSERT_NOW(a_invalid_zero, clk, rst_n, result_valid && !mean_valid, mean_q8 == '0)

    // the count never exceeds the ring depth
    `WMG_ASSERT_NOW(a_count_bound, clk, rst_n, result_valid, 32'(valid_total) <= WINDOW_MAX)

endmodule

bind windowed_mean_with_gaps wmg_checker #(
    .WINDOW_MAX    (WINDOW_MAX),
    .SAMPLE_BITS   (SAMPLE_BITS),
    .FRACTION_BITS (FRACTION_BITS)
) u_wmg_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .mean_q8      (mean_q8),
    .mean_valid   (mean_valid),
    .valid_total  (valid_total)
);

`default_nettype wire

/* sim/windowed_mean_with_gaps_tb.sv */
// ----------------------------------------------------------------------------
// windowed_mean_with_gaps_tb
// Self-checking bench for the windowed moving average with missing samples.
// Requests are driven from a backlog with random gaps. A local model of the
// sample ring predicts every result, and each returned result is checked
// field by field. The bench steps through several window and threshold
// settings over the register port and reads each register back. Near the
// end the idling stops, and at one point the result side holds off long
// enough to back up the sample side.
// ----------------------------------------------------------------------------
module windowed_mean_with_gaps_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import wmg_pkg::*;

    localparam int WINDOW_MAX = WINDOW_MAX_DEF;
    localparam int SBITS      = SAMPLE_BITS_DEF;
    localparam int FBITS      = FRACTION_BITS_DEF;
    localparam int MBITS      = SBITS + FBITS;
    localparam int TBITS      = $clog2(WINDOW_MAX + 1);

    localparam logic [PADDR_BITS-1:0] WINDOW_SIZE_ADDR = {REG_WINDOW_SIZE, 2'b00};
    localparam logic [PADDR_BITS-1:0] MIN_VALID_ADDR   = {REG_MIN_VALID, 2'b00};

    localparam int CYCLE_LIMIT      = 600000;
    localparam int LONG_HOLD_AT     = 300;
    localparam int LONG_HOLD_CYCLES = 500;
    localparam int DRAIN_CYCLES     = 60;
    localparam int NUM_PHASES       = 12;

    typedef struct packed {
        logic signed [SBITS-1:0] value;
        logic                    present;
    } sample_req_t;

    typedef struct packed {
        logic [MBITS-1:0] mean;
        logic             mean_ok;
        logic [TBITS-1:0] total;
    } mean_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    sample_valid;
    logic                    sample_stall;
    logic signed [SBITS-1:0] sample;
    logic                    sample_present;
    logic                    result_valid;
    logic                    result_stall;
    logic signed [MBITS-1:0] mean_q8;
    logic                    mean_valid;
    logic [TBITS-1:0]        valid_total;
    logic                    psel;
    logic                    penable;
    logic                    pwrite;
    logic [PADDR_BITS-1:0]   paddr;
    logic [PDATA_BITS-1:0]   pwdata;
    logic [PDATA_BITS-1:0]   prdata;
    logic                    pready;

    windowed_mean_with_gaps dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .sample_valid   (sample_valid),
        .sample_stall   (sample_stall),
        .sample         (sample),
        .sample_present (sample_present),
        .result_valid   (result_valid),
        .result_stall   (result_stall),
        .mean_q8        (mean_q8),
        .mean_valid     (mean_valid),
        .valid_total    (valid_total),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    // model of the sample ring and its settings
    logic [REG_BITS-1:0]     cfg_window;
    logic [REG_BITS-1:0]     cfg_min_valid;
    logic signed [SBITS-1:0] ring_value [WINDOW_MAX];
    bit                      ring_present [WINDOW_MAX];
    int unsigned             ring_slot;
    longint                  ring_sum;
    int unsigned             ring_count;

    sample_req_t  sample_backlog [$];
    mean_result_t pending_means [$];

    int  issued_count;
    int  accepted_count;
    int  results_seen;
    int  error_count;
    int  settings_count;
    int  cycle_count;
    int  send_gap;
    int  stall_left;
    int  hold_left;
    bit  hold_started;
    bit  quiet_tail;

    always #5 clk = ~clk;

    task automatic report_mismatch(input string what);
        error_count++;
        $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function automatic void clear_window();
        for (int i = 0; i < WINDOW_MAX; i++)
        begin
            ring_value[i]   = '0;
            ring_present[i] = 1'b0;
        end
        ring_slot  = 0;
        ring_sum   = 0;
        ring_count = 0;
    endfunction

    // steps the ring by one sample and returns the mean that follows
    function automatic mean_result_t advance_window(input sample_req_t req);
        int unsigned  size;
        int unsigned  slot;
        int unsigned  threshold;
        longint       mean;
        mean_result_t res;
        size = (cfg_window == 0) ? 1 : (cfg_window > WINDOW_MAX) ? WINDOW_MAX : cfg_window;
        slot = (ring_slot >= size) ? 0 : ring_slot;
        if (ring_present[slot])
        begin
            ring_sum -= longint'(ring_value[slot]);
            if (ring_count > 0)
                ring_count--;
        end
        if (req.present)
        begin
            ring_value[slot]   = req.value;
            ring_present[slot] = 1'b1;
            ring_sum          += longint'(req.value);
            ring_count++;
        end
        else
        begin
            ring_value[slot]   = '0;
            ring_present[slot] = 1'b0;
        end
        slot++;
        ring_slot = (slot >= size) ? 0 : slot;
        threshold   = (cfg_min_valid != 0) ? cfg_min_valid : (size + 1) / 2;
        res.mean_ok = (ring_count > 0) && (ring_count >= threshold);
        mean        = res.mean_ok ? (ring_sum * (longint'(1) << FBITS)) / longint'(ring_count) : 0;
        res.mean    = mean[MBITS-1:0];
        res.total   = ring_count[TBITS-1:0];
        return res;
    endfunction

    task automatic queue_sample(input logic signed [SBITS-1:0] value, input logic present);
        sample_backlog.insert(sample_backlog.size(), '{value: value, present: present});
        issued_count++;
    endtask

    task automatic wait_for_drain();
        @(posedge clk);
        while (accepted_count != issued_count || pending_means.size() != 0)
            @(posedge clk);
    endtask

    task automatic check_register(input logic [PADDR_BITS-1:0] addr,
                                  input logic [REG_BITS-1:0] want);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== PDATA_BITS'(want))
            report_mismatch($sformatf("register at 0x%0h reads %0d, written %0d",
                                      addr, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_register(input logic [PADDR_BITS-1:0] addr,
                                    input logic [REG_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= PDATA_BITS'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == WINDOW_SIZE_ADDR)
        begin
            cfg_window = value;
            clear_window();
        end
        else
            cfg_min_valid = value;
        settings_count++;
        check_register(addr, value);
    endtask

    // sample side: next request from the backlog, random gaps between requests
    always @(posedge clk or negedge rst_n)
    begin
        sample_req_t  req;
        mean_result_t res;
        if (!rst_n)
        begin
            sample_valid   <= 1'b0;
            sample         <= '0;
            sample_present <= 1'b0;
            send_gap       <= 0;
            accepted_count <= 0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
            begin
                res = advance_window('{value: sample, present: sample_present});
                pending_means.insert(pending_means.size(), res);
                accepted_count <= accepted_count + 1;
            end
            if (!sample_valid || !sample_stall)
            begin
                if (send_gap > 0)
                begin
                    sample_valid <= 1'b0;
                    send_gap     <= send_gap - 1;
                end
                else if (sample_backlog.size() > 0)
                begin
                    req = sample_backlog[0];
                    sample_backlog.delete(0);
                    sample_valid   <= 1'b1;
                    sample         <= req.value;
                    sample_present <= req.present;
                    if (!quiet_tail && $urandom_range(0, 5) == 0)
                        send_gap <= $urandom_range(1, 16);
                end
                else
                    sample_valid <= 1'b0;
            end
        end
    end

    // result side stall: one long hold, otherwise random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            hold_started <= 1'b0;
        end
        else if (!hold_started && results_seen >= LONG_HOLD_AT)
        begin
            hold_started <= 1'b1;
            hold_left    <= LONG_HOLD_CYCLES;
            result_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            result_stall <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left   <= stall_left - 1;
            result_stall <= 1'b1;
        end
        else if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            stall_left   <= $urandom_range(0, 15);
            result_stall <= 1'b1;
        end
        else
            result_stall <= 1'b0;
    end

    always @(posedge clk or negedge rst_n)
    begin
        mean_result_t want;
        if (!rst_n)
            results_seen <= 0;
        else if (result_valid && !result_stall)
        begin
            results_seen <= results_seen + 1;
            if (pending_means.size() == 0)
                report_mismatch($sformatf("result %0d with no request outstanding, mean_q8 %0d",
                                          results_seen, mean_q8));
            else
            begin
                want = pending_means[0];
                pending_means.delete(0);
                if (mean_q8 !== want.mean)
                    report_mismatch($sformatf("result %0d mean_q8 %0d, predicted %0d",
                                              results_seen, mean_q8, $signed(want.mean)));
                if (mean_valid !== want.mean_ok)
                    report_mismatch($sformatf("result %0d mean_valid %b, predicted %b",
                                              results_seen, mean_valid, want.mean_ok));
                if (valid_total !== want.total)
                    report_mismatch($sformatf("result %0d valid_total %0d, predicted %0d",
                                              results_seen, valid_total, want.total));
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, pending_means.size());
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        // per phase: window (-1 keeps it), threshold, request count, percent present
        int phase_window  [NUM_PHASES] = '{1, 0, 64, 127, 8, -1, 3, 17, 100, 33, 2, 12};
        int phase_min     [NUM_PHASES] = '{0, 1, 0, 64, 9, 127, 2, 0, 1, 20, 0, 5};
        int phase_items   [NUM_PHASES] = '{60, 40, 200, 150, 60, 40, 100, 130, 100, 100, 60, 100};
        int phase_percent [NUM_PHASES] = '{70, 50, 90, 95, 80, 80, 60, 75, 30, 85, 50, 70};
        logic signed [SBITS-1:0] value;

        clk            = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cycle_count    = 0;
        issued_count   = 0;
        error_count    = 0;
        settings_count = 1;
        quiet_tail     = 1'b0;
        cfg_window     = WINDOW_SIZE_RESET;
        cfg_min_valid  = MIN_VALID_RESET;
        clear_window();

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        check_register(WINDOW_SIZE_ADDR, WINDOW_SIZE_RESET);
        check_register(MIN_VALID_ADDR, MIN_VALID_RESET);

        // directed: extremes, missing samples with junk values, rounding of negatives
        queue_sample(16'sh7fff, 1'b1);
        queue_sample(16'sh7fff, 1'b1);
        queue_sample(16'sh7fff, 1'b1);
        queue_sample(16'sh5a5a, 1'b0);
        queue_sample(-16'sd1, 1'b0);
        queue_sample(16'sh7fff, 1'b1);
        queue_sample(-16'sd32768, 1'b1);
        queue_sample(-16'sd32768, 1'b1);
        queue_sample(-16'sd32768, 1'b1);
        queue_sample(-16'sd32768, 1'b1);
        queue_sample(-16'sd32768, 1'b1);
        queue_sample(-16'sd1, 1'b1);
        queue_sample(16'sd0, 1'b1);
        queue_sample(16'sd0, 1'b1);
        queue_sample(16'sh7fff, 1'b0);
        queue_sample(-16'sd32768, 1'b0);
        queue_sample(16'sd1, 1'b1);
        queue_sample(-16'sd2, 1'b1);
        queue_sample(16'sd0, 1'b0);
        queue_sample(16'sd0, 1'b0);
        queue_sample(16'sd0, 1'b0);
        queue_sample(16'sd0, 1'b0);
        queue_sample(16'sd0, 1'b0);
        queue_sample(16'sd7, 1'b1);
        wait_for_drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            if (p == NUM_PHASES - 1)
                quiet_tail = 1'b1;
            if (phase_window[p] >= 0)
                program_register(WINDOW_SIZE_ADDR, REG_BITS'(phase_window[p]));
            program_register(MIN_VALID_ADDR, REG_BITS'(phase_min[p]));
            for (int i = 0; i < phase_items[p]; i++)
            begin
                case ($urandom_range(0, 15))
                    0:       value = 16'sh7fff;
                    1:       value = -16'sd32768;
                    2:       value = SBITS'($urandom_range(0, 3)) - 16'sd2;
                    default: value = SBITS'($urandom);
                endcase
                queue_sample(value, $urandom_range(0, 99) < phase_percent[p]);
            end
            wait_for_drain();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("checked %0d results over %0d register settings, windows 1 to 64,",
                 results_seen, settings_count);
        $display("thresholds from default to beyond the window, with long result hold-off");
        if (error_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/wmg_pkg.sv
hw/rtl/wmg_ring.sv
hw/rtl/wmg_div.sv
hw/rtl/windowed_mean_with_gaps.sv
hw/rtl/wmg_checker.sv
sim/windowed_mean_with_gaps_tb.sv
